### hw/rtl/itmr_pkg.sv
// Shared types, constants and register codes for the image threshold/mirror/turn unit.
// No dependencies; every other file of the block but itmr_ram imports this package.
`default_nettype none

package itmr_pkg;

    // Frame geometry limits and pixel width
    localparam int MAX_COLS    = 64;
    localparam int MAX_ROWS    = 64;
    localparam int PIXEL_BITS  = 8;
    localparam int STORE_DEPTH = MAX_COLS * MAX_ROWS;

    localparam int COL_W  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int ROW_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int ADDR_W = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int CNT_W  = $clog2(STORE_DEPTH + 1);

    // Register field widths
    localparam int DIM_W     = 7;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 8;

    // Reset values of the registers
    localparam logic [DIM_W-1:0]      COLS_RESET  = DIM_W'(64);
    localparam logic [DIM_W-1:0]      ROWS_RESET  = DIM_W'(64);
    localparam logic [PIXEL_BITS-1:0] LEVEL_RESET = PIXEL_BITS'(100);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FRAME_COLS    = 3'd0,
        REG_FRAME_ROWS    = 3'd1,
        REG_CUT_LEVEL     = 3'd2,
        REG_CUT_ENABLE    = 3'd3,
        REG_MIRROR_ENABLE = 3'd4,
        REG_TURN_ENABLE   = 3'd5
    } cfg_idx_t;

    typedef enum logic {
        OP_LOAD = 1'b0,
        OP_READ = 1'b1
    } op_t;

    // Settings as the datapath sees them, geometry already clamped to 1..MAX
    typedef struct packed {
        logic [DIM_W-1:0]      cols;
        logic [DIM_W-1:0]      rows;
        logic [PIXEL_BITS-1:0] cut_level;
        logic                  cut_enable;
        logic                  mirror_enable;
        logic                  turn_enable;
    } geom_t;

    // Frame store access and position marks from the address generator
    typedef struct packed {
        logic                  wr_en;
        logic [ADDR_W-1:0]     wr_addr;
        logic [ADDR_W-1:0]     rd_addr;
        logic                  row_end;
        logic                  frame_end;
    } mem_ctl_t;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                   input logic [DIM_W-1:0] maxv);
        logic [DIM_W-1:0] r;
        if (v == '0)
            r = DIM_W'(1);
        else if (v > maxv)
            r = maxv;
        else
            r = v;
        return r;
    endfunction

endpackage

`default_nettype wire

### hw/rtl/itmr_if.sv
// Handshake channel interfaces: input beats, result beats and register writes.
// Depends on itmr_pkg for payload widths.
`default_nettype none

interface itmr_in_if;
    import itmr_pkg::*;
    logic                  valid;
    logic                  ready;
    logic                  op;
    logic [PIXEL_BITS-1:0] pixel_in;
    modport source (output valid, output op, output pixel_in, input ready);
    modport sink   (input valid, input op, input pixel_in, output ready);
endinterface

interface itmr_out_if;
    import itmr_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [PIXEL_BITS-1:0] pixel_out;
    logic                  is_set;
    logic                  row_end;
    logic                  frame_end;
    modport source (output valid, output pixel_out, output is_set, output row_end,
                    output frame_end, input ready);
    modport sink   (input valid, input pixel_out, input is_set, input row_end,
                    input frame_end, output ready);
endinterface

interface itmr_cfg_if;
    import itmr_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_DAT_W-1:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

### hw/rtl/image_threshold_mirror_rotate_unit.sv
// Image threshold / mirror / clockwise-turn unit: a 64x64 frame store loaded in raster
// order and read back transformed. Load beats (op 0) write the next store entry until
// the frame is full; later loads are dropped. Read beats (op 1) each produce one result
// beat: the next pixel of the mirrored, then turned frame in output raster order, zeroed
// when thresholding is on and it is at or below the cut level, with a nonzero flag and
// end-of-row / end-of-frame marks. Reading wraps to the start after the frame end.
// Throughput is one beat per clock unless the output stalls: a read passes the RAM read
// register (address and RAM read), then is thresholded into the output register.
// Register writes are accepted at any time but must be issued only while the unit is
// idle. The frame store has no reset; reading pixels that were never loaded is undefined.
// Depends on itmr_pkg, itmr_if, itmr_ram, itmr_cfg_regs and itmr_addr_gen.
`default_nettype none

module image_threshold_mirror_rotate_unit (
    input  logic       clk,
    input  logic       rst_n,
    itmr_in_if.sink    in_ch,
    itmr_out_if.source out_ch,
    itmr_cfg_if.sink   cfg_ch
);
    import itmr_pkg::*;

    geom_t                 geom;
    mem_ctl_t              ctl;
    logic                  in_fire;
    logic                  ld_go;
    logic                  rd_go;
    logic                  advance;
    logic [PIXEL_BITS-1:0] ram_q;
    logic [PIXEL_BITS-1:0] pix_cut;

    // Read stage: RAM data is in flight, marks wait beside it
    logic                  s1_valid_reg;
    logic                  s1_valid_next;
    logic                  s1_row_end_reg;
    logic                  s1_frame_end_reg;

    // Output register
    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic [PIXEL_BITS-1:0] out_pixel_reg;
    logic                  out_set_reg;
    logic                  out_row_end_reg;
    logic                  out_frame_end_reg;

    itmr_cfg_regs u_cfg (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg_ch (cfg_ch),
        .geom   (geom)
    );

    itmr_addr_gen u_addr (
        .clk   (clk),
        .rst_n (rst_n),
        .geom  (geom),
        .ld_go (ld_go),
        .rd_go (rd_go),
        .ctl   (ctl)
    );

    itmr_ram #(
        .DATA_W (PIXEL_BITS),
        .ADDR_W (ADDR_W)
    ) u_store (
        .clk   (clk),
        .we    (ctl.wr_en),
        .waddr (ctl.wr_addr),
        .wdata (in_ch.pixel_in),
        .re    (rd_go),
        .raddr (ctl.rd_addr),
        .rdata (ram_q)
    );

    // Advance the read stage when the output register is free or being drained;
    // take a new beat whenever the read stage will be empty after this edge.
    assign advance     = s1_valid_reg && (!out_valid_reg || out_ch.ready);
    assign in_ch.ready = !s1_valid_reg || advance;
    assign in_fire     = in_ch.valid && in_ch.ready;
    assign ld_go       = in_fire && (in_ch.op == OP_LOAD);
    assign rd_go       = in_fire && (in_ch.op == OP_READ);

    always_comb
    begin
        // Zero pixels at or below the cut level when thresholding is on
        if (geom.cut_enable && (ram_q <= geom.cut_level))
            pix_cut = '0;
        else
            pix_cut = ram_q;

        if (rd_go)
            s1_valid_next = 1'b1;
        else if (advance)
            s1_valid_next = 1'b0;
        else
            s1_valid_next = s1_valid_reg;

        if (advance)
            out_valid_next = 1'b1;
        else if (out_ch.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload: hold the marks with the RAM read, move both on advance
    always_ff @(posedge clk)
    begin
        if (rd_go)
        begin
            s1_row_end_reg   <= ctl.row_end;
            s1_frame_end_reg <= ctl.frame_end;
        end
        if (advance)
        begin
            out_pixel_reg     <= pix_cut;
            out_set_reg       <= (pix_cut != '0);
            out_row_end_reg   <= s1_row_end_reg;
            out_frame_end_reg <= s1_frame_end_reg;
        end
    end

    assign out_ch.valid     = out_valid_reg;
    assign out_ch.pixel_out = out_pixel_reg;
    assign out_ch.is_set    = out_set_reg;
    assign out_ch.row_end   = out_row_end_reg;
    assign out_ch.frame_end = out_frame_end_reg;

endmodule

`default_nettype wire

### hw/rtl/itmr_ram.sv
// Generic single-write, single-read synchronous RAM with a registered read port.
// No package dependency.
`default_nettype none

module itmr_ram #(
    parameter int DATA_W = 8,
    parameter int ADDR_W = 12
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [(1 << ADDR_W)];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

### hw/rtl/itmr_cfg_regs.sv
// Register file for geometry, threshold and transform enables.
// Depends on itmr_pkg and the itmr_cfg_if channel.
`default_nettype none

module itmr_cfg_regs (
    input  logic            clk,
    input  logic            rst_n,
    itmr_cfg_if.sink        cfg_ch,
    output itmr_pkg::geom_t geom
);
    import itmr_pkg::*;

    logic [DIM_W-1:0]      cols_reg;
    logic [DIM_W-1:0]      rows_reg;
    logic [PIXEL_BITS-1:0] level_reg;
    logic                  cut_en_reg;
    logic                  mirror_reg;
    logic                  turn_reg;

    assign cfg_ch.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cols_reg   <= COLS_RESET;
            rows_reg   <= ROWS_RESET;
            level_reg  <= LEVEL_RESET;
            cut_en_reg <= 1'b1;
            mirror_reg <= 1'b0;
            turn_reg   <= 1'b0;
        end
        else if (cfg_ch.valid)
        begin
            case (cfg_idx_t'(cfg_ch.index))
                REG_FRAME_COLS:    cols_reg   <= cfg_ch.data[DIM_W-1:0];
                REG_FRAME_ROWS:    rows_reg   <= cfg_ch.data[DIM_W-1:0];
                REG_CUT_LEVEL:     level_reg  <= cfg_ch.data[PIXEL_BITS-1:0];
                REG_CUT_ENABLE:    cut_en_reg <= cfg_ch.data[0];
                REG_MIRROR_ENABLE: mirror_reg <= cfg_ch.data[0];
                REG_TURN_ENABLE:   turn_reg   <= cfg_ch.data[0];
                default:           ; // drop writes beyond the list
            endcase
        end
    end

    always_comb
    begin
        geom.cols          = clamp_dim(cols_reg, DIM_W'(MAX_COLS));
        geom.rows          = clamp_dim(rows_reg, DIM_W'(MAX_ROWS));
        geom.cut_level     = level_reg;
        geom.cut_enable    = cut_en_reg;
        geom.mirror_enable = mirror_reg;
        geom.turn_enable   = turn_reg;
    end

endmodule

`default_nettype wire

### hw/rtl/itmr_addr_gen.sv
// Load counter, output raster position and frame store address generation.
// Depends on itmr_pkg.
`default_nettype none

module itmr_addr_gen (
    input  logic               clk,
    input  logic               rst_n,
    input  itmr_pkg::geom_t    geom,
    input  logic               ld_go,
    input  logic               rd_go,
    output itmr_pkg::mem_ctl_t ctl
);
    import itmr_pkg::*;

    logic [CNT_W-1:0]   load_cnt_reg;
    logic [CNT_W-1:0]   load_cnt_next;
    logic [ROW_W-1:0]   out_row_reg;
    logic [ROW_W-1:0]   out_row_next;
    logic [COL_W-1:0]   out_col_reg;
    logic [COL_W-1:0]   out_col_next;

    logic [2*DIM_W-1:0] total;
    logic               room;
    logic [DIM_W-1:0]   o_rows;
    logic [DIM_W-1:0]   o_cols;
    logic               outside;
    logic [DIM_W-1:0]   row_eff;
    logic [DIM_W-1:0]   col_eff;
    logic [DIM_W-1:0]   src_r;
    logic [DIM_W-1:0]   src_c;
    logic [2*DIM_W-1:0] addr_full;
    logic               last_col;
    logic               last_row;

    always_comb
    begin
        total = geom.cols * geom.rows;
        room  = ({1'b0, load_cnt_reg} < total);

        o_rows  = geom.turn_enable ? geom.cols : geom.rows;
        o_cols  = geom.turn_enable ? geom.rows : geom.cols;
        outside = (DIM_W'(out_row_reg) >= o_rows) || (DIM_W'(out_col_reg) >= o_cols);
        row_eff = outside ? '0 : DIM_W'(out_row_reg);
        col_eff = outside ? '0 : DIM_W'(out_col_reg);

        // Turn clockwise: output column walks the input rows from the bottom
        if (geom.turn_enable)
        begin
            src_r = geom.rows - DIM_W'(1) - col_eff;
            src_c = row_eff;
        end
        else
        begin
            src_r = row_eff;
            src_c = col_eff;
        end
        if (geom.mirror_enable)
        begin
            src_c = geom.cols - DIM_W'(1) - src_c;
        end
        addr_full = src_r * geom.cols + (2*DIM_W)'(src_c);

        last_col = (col_eff == o_cols - DIM_W'(1));
        last_row = (row_eff == o_rows - DIM_W'(1));

        ctl.wr_en     = ld_go && room;
        ctl.wr_addr   = load_cnt_reg[ADDR_W-1:0];
        ctl.rd_addr   = addr_full[ADDR_W-1:0];
        ctl.row_end   = last_col;
        ctl.frame_end = last_col && last_row;

        load_cnt_next = ctl.wr_en ? load_cnt_reg + CNT_W'(1) : load_cnt_reg;

        out_row_next = out_row_reg;
        out_col_next = out_col_reg;
        if (rd_go)
        begin
            if (!last_col)
            begin
                out_row_next = row_eff[ROW_W-1:0];
                out_col_next = col_eff[COL_W-1:0] + COL_W'(1);
            end
            else
            begin
                out_col_next = '0;
                out_row_next = last_row ? '0 : row_eff[ROW_W-1:0] + ROW_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            load_cnt_reg <= '0;
            out_row_reg  <= '0;
            out_col_reg  <= '0;
        end
        else
        begin
            load_cnt_reg <= load_cnt_next;
            out_row_reg  <= out_row_next;
            out_col_reg  <= out_col_next;
        end
    end

endmodule

`default_nettype wire
